>>> hw/rtl/ket_pkg.sv
// Shared types, constants and lookup tables for the keyboard event tracker.
// No dependencies; imported by ket_ctrl, ket_dpath and keyboard_event_tracker.

package ket_pkg;

	localparam int SLOT_COUNT = 2048;
	localparam int SLOT_AW    = $clog2(SLOT_COUNT);

	// Item command codes
	localparam logic [1:0] CMD_EVENT = 2'd0;
	localparam logic [1:0] CMD_QUERY = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// Modifier scan codes
	localparam logic [7:0] SC_ALT_L   = 8'h38;
	localparam logic [7:0] SC_ALT_R   = 8'hb8;
	localparam logic [7:0] SC_CTRL_L  = 8'h1d;
	localparam logic [7:0] SC_CTRL_R  = 8'h9d;
	localparam logic [7:0] SC_SHIFT_L = 8'h2a;
	localparam logic [7:0] SC_SHIFT_R = 8'h36;

	// Slot state codes
	localparam logic [2:0] SLOT_IDLE     = 3'd0;
	localparam logic [2:0] SLOT_DOWN     = 3'd1;
	localparam logic [2:0] SLOT_SEEN     = 3'd2;
	localparam logic [2:0] SLOT_REPEAT   = 3'd3;
	localparam logic [2:0] SLOT_RELEASED = 3'd4;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;
		logic rd_en;
		logic held_we;
		logic finish;
		logic sweep_we;
	} ket_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_valid;
		logic sweep_last;
	} ket_sts_t;

	// Unshifted scan code translation
	function automatic logic [6:0] scan_ascii(input logic [7:0] sc);
		logic [6:0] ch;
		unique case (sc)
			8'h02: ch = 7'h31;
			8'h03: ch = 7'h32;
			8'h04: ch = 7'h33;
			8'h05: ch = 7'h34;
			8'h06: ch = 7'h35;
			8'h07: ch = 7'h36;
			8'h08: ch = 7'h37;
			8'h09: ch = 7'h38;
			8'h0a: ch = 7'h39;
			8'h0b: ch = 7'h30;
			8'h0c: ch = 7'h2d;
			8'h0d: ch = 7'h3d;
			8'h0e: ch = 7'h08;
			8'h0f: ch = 7'h09;
			8'h10: ch = 7'h71;
			8'h11: ch = 7'h77;
			8'h12: ch = 7'h65;
			8'h13: ch = 7'h72;
			8'h14: ch = 7'h74;
			8'h15: ch = 7'h79;
			8'h16: ch = 7'h75;
			8'h17: ch = 7'h69;
			8'h18: ch = 7'h6f;
			8'h19: ch = 7'h70;
			8'h1a: ch = 7'h5b;
			8'h1b: ch = 7'h5d;
			8'h1c: ch = 7'h0d;
			8'h1e: ch = 7'h61;
			8'h1f: ch = 7'h73;
			8'h20: ch = 7'h64;
			8'h21: ch = 7'h66;
			8'h22: ch = 7'h67;
			8'h23: ch = 7'h68;
			8'h24: ch = 7'h6a;
			8'h25: ch = 7'h6b;
			8'h26: ch = 7'h6c;
			8'h27: ch = 7'h3b;
			8'h28: ch = 7'h27;
			8'h29: ch = 7'h7e;
			8'h2b: ch = 7'h5c;
			8'h2c: ch = 7'h7a;
			8'h2d: ch = 7'h78;
			8'h2e: ch = 7'h63;
			8'h2f: ch = 7'h76;
			8'h30: ch = 7'h62;
			8'h31: ch = 7'h6e;
			8'h32: ch = 7'h6d;
			8'h33: ch = 7'h2c;
			8'h34: ch = 7'h2e;
			8'h35: ch = 7'h2f;
			8'h37: ch = 7'h2a;
			8'h39: ch = 7'h20;
			8'h47: ch = 7'h37;
			8'h48: ch = 7'h38;
			8'h49: ch = 7'h39;
			8'h4a: ch = 7'h2d;
			8'h4b: ch = 7'h34;
			8'h4c: ch = 7'h35;
			8'h4d: ch = 7'h36;
			8'h4e: ch = 7'h2b;
			8'h4f: ch = 7'h31;
			8'h50: ch = 7'h32;
			8'h51: ch = 7'h33;
			8'h52: ch = 7'h30;
			8'h53: ch = 7'h2e;
			8'h8d: ch = 7'h3d;
			8'h90: ch = 7'h7e;
			8'h91: ch = 7'h40;
			8'h92: ch = 7'h3a;
			8'h93: ch = 7'h5f;
			8'h9c: ch = 7'h0d;
			8'hb3: ch = 7'h2c;
			8'hb5: ch = 7'h2f;
			8'hcb: ch = 7'h02;
			8'hcd: ch = 7'h06;
			8'hd3: ch = 7'h7f;
			default: ch = 7'h00;
		endcase
		return ch;
	endfunction

	// Shifted symbol override by offset from scan code 0x02; zero means none
	function automatic logic [6:0] shifted_sym(input logic [5:0] off);
		logic [6:0] ch;
		unique case (off)
			6'h00: ch = 7'h21;
			6'h01: ch = 7'h40;
			6'h02: ch = 7'h23;
			6'h03: ch = 7'h24;
			6'h04: ch = 7'h25;
			6'h05: ch = 7'h5e;
			6'h06: ch = 7'h26;
			6'h07: ch = 7'h2a;
			6'h08: ch = 7'h28;
			6'h09: ch = 7'h29;
			6'h0a: ch = 7'h5f;
			6'h0b: ch = 7'h2b;
			6'h18: ch = 7'h7b;
			6'h19: ch = 7'h7d;
			6'h25: ch = 7'h3a;
			6'h26: ch = 7'h22;
			6'h27: ch = 7'h7e;
			6'h29: ch = 7'h7c;
			6'h31: ch = 7'h3c;
			6'h32: ch = 7'h3e;
			6'h33: ch = 7'h3f;
			default: ch = 7'h00;
		endcase
		return ch;
	endfunction

	// Full translation of a modifier-combined slot index
	function automatic logic [6:0] translate(input logic [10:0] idx);
		logic [6:0] ch;
		logic [7:0] off;
		logic [6:0] sym;
		ch  = scan_ascii(idx[7:0]);
		off = idx[7:0] - 8'h02;
		sym = shifted_sym(off[5:0]);
		// upper-case letters under shift
		if (ch >= 7'h61 && ch <= 7'h7a && idx[10]) begin
			ch = ch - 7'h20;
		end
		// shift-only symbols for scan codes 0x02 to 0x35
		if (idx[10:8] == 3'b100 && idx[7:0] >= 8'h02 && idx[7:0] <= 8'h35 && sym != 7'h00) begin
			ch = sym;
		end
		return ch;
	endfunction

endpackage

>>> hw/rtl/ket_dpath.sv
// Datapath of the keyboard event tracker: item registers, modifier state,
// slot state memory, clearing counter and the result register. Uses ket_pkg.

module ket_dpath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ket_pkg::ket_cmd_t       cmd_i,
	output ket_pkg::ket_sts_t       sts,
	input  logic [1:0]              cmd,
	input  logic [7:0]              scan_code,
	input  logic                    pressed,
	input  logic [10:0]             key_index,
	input  logic                    out_stall,
	output logic                    out_valid,
	output logic [10:0]             slot_index,
	output logic [2:0]              slot_state,
	output logic [2:0]              modifier_flags,
	output logic [6:0]              ascii_code,
	output logic                    ascii_valid
);
	import ket_pkg::*;

	// Item registers
	logic [1:0]         cmd_q;
	logic               pressed_q;
	logic [7:0]         scan_q;
	logic [SLOT_AW-1:0] idx_q;
	logic [2:0]         flags_q;
	logic               held_chk_q;

	// State
	logic [2:0]         mods_q;
	logic [SLOT_AW-1:0] sweep_cnt_q;
	logic [2:0]         mem [SLOT_COUNT];
	logic [2:0]         rd_held_q;
	logic [2:0]         rd_slot_q;

	// Result register
	logic               out_valid_q;
	logic [10:0]        res_idx_q;
	logic [2:0]         res_state_q;
	logic [2:0]         res_flags_q;
	logic [6:0]         res_ascii_q;
	logic               res_avalid_q;

	logic [2:0]         mod_bit;
	logic               is_event_q;
	logic               is_query_q;
	logic [2:0]         new_state;
	logic               slot_we;
	logic               held_we;
	logic               mem_we;
	logic [SLOT_AW-1:0] mem_waddr;
	logic [2:0]         mem_wdata;

	// Decode modifier keys: bit0 alt, bit1 ctrl, bit2 shift
	always_comb begin
		mod_bit = 3'b000;
		if (scan_code == SC_ALT_L || scan_code == SC_ALT_R) begin
			mod_bit = 3'b001;
		end else if (scan_code == SC_CTRL_L || scan_code == SC_CTRL_R) begin
			mod_bit = 3'b010;
		end else if (scan_code == SC_SHIFT_L || scan_code == SC_SHIFT_R) begin
			mod_bit = 3'b100;
		end
	end

	// Capture the item and form the combined slot index
	always_ff @(posedge clk) begin
		if (cmd_i.accept) begin
			cmd_q      <= cmd;
			pressed_q  <= pressed;
			scan_q     <= scan_code;
			held_chk_q <= (cmd == CMD_EVENT) && (mod_bit == 3'b000) && (mods_q != 3'b000);
			if (cmd == CMD_QUERY) begin
				idx_q   <= key_index;
				flags_q <= 3'b000;
			end else if (mod_bit != 3'b000) begin
				idx_q   <= {3'b000, scan_code};
				flags_q <= 3'b000;
			end else begin
				idx_q   <= {mods_q[2], mods_q[1], mods_q[0], scan_code};
				flags_q <= {mods_q[0], mods_q[1], mods_q[2]};
			end
		end
	end

	// Track modifiers; clear drops them all
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mods_q <= 3'b000;
		end else if (cmd_i.accept) begin
			if (cmd == CMD_CLEAR) begin
				mods_q <= 3'b000;
			end else if (cmd == CMD_EVENT && mod_bit != 3'b000) begin
				mods_q <= pressed ? (mods_q | mod_bit) : (mods_q & ~mod_bit);
			end
		end
	end

	// Advance the clearing counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_cnt_q <= '0;
		end else if (cmd_i.sweep_we) begin
			sweep_cnt_q <= sweep_cnt_q + 1'b1;
		end
	end

	assign sts.sweep_last = &sweep_cnt_q;
	assign sts.out_valid  = out_valid_q;

	assign is_event_q = (cmd_q == CMD_EVENT);
	assign is_query_q = (cmd_q == CMD_QUERY);

	// Next slot state for an event or a query
	always_comb begin
		if (is_event_q) begin
			if (pressed_q) begin
				new_state = (rd_slot_q == SLOT_DOWN) ? SLOT_REPEAT : SLOT_DOWN;
			end else begin
				new_state = rd_slot_q | SLOT_RELEASED;
			end
		end else if (rd_slot_q[2]) begin
			new_state = SLOT_IDLE;
		end else if (rd_slot_q == SLOT_DOWN) begin
			new_state = SLOT_SEEN;
		end else begin
			new_state = rd_slot_q;
		end
	end

	// Select the single memory write
	assign held_we = cmd_i.held_we && held_chk_q && (rd_held_q != SLOT_IDLE);
	assign slot_we = cmd_i.finish && (is_event_q || is_query_q);
	assign mem_we  = cmd_i.sweep_we || held_we || slot_we;

	always_comb begin
		if (cmd_i.sweep_we) begin
			mem_waddr = sweep_cnt_q;
			mem_wdata = SLOT_IDLE;
		end else if (held_we) begin
			mem_waddr = {3'b000, scan_q};
			mem_wdata = SLOT_RELEASED;
		end else begin
			mem_waddr = idx_q;
			mem_wdata = new_state;
		end
	end

	// Slot memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (cmd_i.rd_en) begin
			rd_held_q <= mem[{3'b000, scan_q}];
			rd_slot_q <= mem[idx_q];
		end
	end

	// Hold the result until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_i.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.finish) begin
			res_idx_q    <= (is_event_q || is_query_q) ? idx_q : '0;
			res_state_q  <= is_event_q ? new_state : (is_query_q ? rd_slot_q : 3'b000);
			res_flags_q  <= is_event_q ? flags_q : 3'b000;
			res_ascii_q  <= (is_event_q && pressed_q) ? translate(idx_q) : 7'h00;
			res_avalid_q <= is_event_q && pressed_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign slot_index     = res_idx_q;
	assign slot_state     = res_state_q;
	assign modifier_flags = res_flags_q;
	assign ascii_code     = res_ascii_q;
	assign ascii_valid    = res_avalid_q;

`ifndef NO_ASSERTIONS
	// A held-slot write never targets the combined slot of the same item
	a_held_addr: assert property (@(posedge clk) disable iff (!arst_n)
		held_we |-> (idx_q[10:8] != 3'b000))
		else $error("held slot write aliases the combined slot");

	// Clearing and item writes never overlap
	a_sweep_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_i.sweep_we |-> !(cmd_i.held_we || cmd_i.finish || cmd_i.accept))
		else $error("memory clearing overlaps item work");

	// A result loaded at finish is presented in the next cycle
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_i.finish |=> out_valid_q)
		else $error("result not presented after finish");
`endif

endmodule

>>> hw/rtl/ket_ctrl.sv
// Controller of the keyboard event tracker: sequences memory clearing,
// slot reads, held-slot and slot writes, and result hand-off. Uses ket_pkg.

module ket_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        cmd,
	input  logic              out_stall,
	input  ket_pkg::ket_sts_t sts,
	output ket_pkg::ket_cmd_t cmd_o,
	output logic              in_stall
);
	import ket_pkg::*;

	typedef enum logic [4:0] {
		ST_SWEEP  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_READ   = 5'b00100,
		ST_HELD   = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   sweep_pend_q;
	logic   accept;
	logic   out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign out_free = !sts.out_valid || !out_stall;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_SWEEP: begin
				if (sts.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = (cmd == CMD_EVENT || cmd == CMD_QUERY) ? ST_READ : ST_FINISH;
				end
			end
			ST_READ: begin
				state_d = ST_HELD;
			end
			ST_HELD: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = sweep_pend_q ? ST_SWEEP : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_SWEEP;
			end
		endcase
	end

	// Reset starts with a clearing pass over the slot memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			sweep_pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				sweep_pend_q <= (cmd == CMD_CLEAR);
			end
		end
	end

	// Datapath commands
	assign cmd_o.accept   = accept;
	assign cmd_o.rd_en    = (state_q == ST_READ);
	assign cmd_o.held_we  = (state_q == ST_HELD);
	assign cmd_o.finish   = (state_q == ST_FINISH) && out_free;
	assign cmd_o.sweep_we = (state_q == ST_SWEEP);

`ifndef NO_ASSERTIONS
	// An accepted item goes to a read or straight to finish
	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_READ || state_q == ST_FINISH))
		else $error("accepted item did not start");

	// Read is always followed by the held-slot step
	a_read_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> (state_q == ST_HELD))
		else $error("read not followed by held step");

	// Clearing continues until the last entry
	a_sweep_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP && !sts.sweep_last) |=> (state_q == ST_SWEEP))
		else $error("clearing pass ended early");

	// A clear command leads into a clearing pass after its result
	a_clear_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_o.finish && sweep_pend_q) |=> (state_q == ST_SWEEP))
		else $error("clear command skipped the clearing pass");
`endif

endmodule

>>> hw/rtl/keyboard_event_tracker.sv
// Keyboard event tracker top level: joins the controller and the datapath.
// Depends on ket_pkg, ket_ctrl and ket_dpath.

// Takes key events (scan code plus press flag), slot queries and clear
// commands, one transaction at a time, and returns exactly one result per
// item. An event or query reads both slots, then may write the bare held slot,
// then writes the combined slot while loading the result register; the two
// writes are split by the single write port of the 2048 x 3 slot memory. A
// clear or unused command goes straight to the result register. Except after
// a clear, the next item is taken in the cycle after a result is loaded.
// After reset, and after every clear command's result, the block runs a
// clearing pass over the whole slot memory during which in_stall stays high.
// A finished result waits in the output register while out_stall is high;
// the next item is then held at its final step until that result is taken.

module keyboard_event_tracker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  scan_code,
	input  logic        pressed,
	input  logic [10:0] key_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [10:0] slot_index,
	output logic [2:0]  slot_state,
	output logic [2:0]  modifier_flags,
	output logic [6:0]  ascii_code,
	output logic        ascii_valid
);
	import ket_pkg::*;

	ket_cmd_t ctl_cmd;
	ket_sts_t dp_sts;

	// Sequence the work
	ket_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.out_stall(out_stall),
		.sts      (dp_sts),
		.cmd_o    (ctl_cmd),
		.in_stall (in_stall)
	);

	// Hold state and compute results
	ket_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_i         (ctl_cmd),
		.sts           (dp_sts),
		.cmd           (cmd),
		.scan_code     (scan_code),
		.pressed       (pressed),
		.key_index     (key_index),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.slot_index    (slot_index),
		.slot_state    (slot_state),
		.modifier_flags(modifier_flags),
		.ascii_code    (ascii_code),
		.ascii_valid   (ascii_valid)
	);

endmodule

>>> dv/ket_checker.sv
// Scoreboard for keyboard_event_tracker: watches the input and result channels,
// tracks modifier and slot state on its own, and compares every result in order.
// Depends on ket_pkg for the slot count and the command, scan and slot codes.

module ket_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  scan_code,
	input  logic        pressed,
	input  logic [10:0] key_index,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [10:0] slot_index,
	input  logic [2:0]  slot_state,
	input  logic [2:0]  modifier_flags,
	input  logic [6:0]  ascii_code,
	input  logic        ascii_valid,
	output int          fail_count,
	output int          pending,
	output int          checked
);
	import ket_pkg::*;

	localparam logic [2:0] MOD_ALT   = 3'b001;
	localparam logic [2:0] MOD_CTRL  = 3'b010;
	localparam logic [2:0] MOD_SHIFT = 3'b100;
	localparam logic [2:0] MOD_NONE  = 3'b000;

	typedef struct packed {
		logic [10:0] slot_index;
		logic [2:0]  slot_state;
		logic [2:0]  modifier_flags;
		logic [6:0]  ascii_code;
		logic        ascii_valid;
	} key_report_t;

	logic [6:0]  base_chars [256];
	logic [6:0]  shift_syms [64];
	logic [2:0]  held_mods;                // bit0 alt, bit1 ctrl, bit2 shift
	logic [2:0]  slot_track [SLOT_COUNT];
	key_report_t report_q [$];

	// Load a run of characters into the plain or the shifted table
	task automatic fill_chars(input int base, input string s, input bit to_shift);
		byte ch;
		for (int i = 0; i < s.len(); i++) begin
			ch = s[i];
			if (to_shift) begin
				shift_syms[base + i] = ch[6:0];
			end else begin
				base_chars[base + i] = ch[6:0];
			end
		end
	endtask

	initial begin
		foreach (base_chars[i]) base_chars[i] = 7'h00;
		foreach (shift_syms[i]) shift_syms[i] = 7'h00;
		fill_chars(8'h02, "1234567890-=", 1'b0);
		fill_chars(8'h10, "qwertyuiop[]", 1'b0);
		fill_chars(8'h1e, "asdfghjkl;'~", 1'b0);
		fill_chars(8'h2b, "\\", 1'b0);
		fill_chars(8'h2c, "zxcvbnm,./", 1'b0);
		fill_chars(8'h37, "*", 1'b0);
		fill_chars(8'h39, " ", 1'b0);
		fill_chars(8'h47, "789-456+1230.", 1'b0);
		fill_chars(8'h8d, "=", 1'b0);
		fill_chars(8'h90, "~@:_", 1'b0);
		fill_chars(8'hb3, ",", 1'b0);
		fill_chars(8'hb5, "/", 1'b0);
		base_chars[8'h0e] = 7'h08;
		base_chars[8'h0f] = 7'h09;
		base_chars[8'h1c] = 7'h0d;
		base_chars[8'h9c] = 7'h0d;
		base_chars[8'hcb] = 7'h02;
		base_chars[8'hcd] = 7'h06;
		base_chars[8'hd3] = 7'h7f;
		// shifted symbols by offset from the shift-only index of scan code 0x02
		fill_chars(8'h00, "!@#$%^&*()_+", 1'b1);
		fill_chars(8'h18, "{}", 1'b1);
		fill_chars(8'h25, ":\"~", 1'b1);
		fill_chars(8'h29, "|", 1'b1);
		fill_chars(8'h31, "<>?", 1'b1);
	end

	function automatic logic [2:0] modifier_of(input logic [7:0] sc);
		case (sc)
			SC_ALT_L, SC_ALT_R:     return MOD_ALT;
			SC_CTRL_L, SC_CTRL_R:   return MOD_CTRL;
			SC_SHIFT_L, SC_SHIFT_R: return MOD_SHIFT;
			default:                return MOD_NONE;
		endcase
	endfunction

	// Character for a combined slot index: upper-case under shift, then symbols
	function automatic logic [6:0] char_for_slot(input logic [10:0] idx);
		logic [6:0]  ch;
		logic [10:0] off;
		ch  = base_chars[idx[7:0]];
		off = idx - 11'h402;
		if (idx[10] && ch >= "a" && ch <= "z") begin
			ch = ch - 7'h20;
		end
		if (idx >= 11'h402 && off < 11'h34 && shift_syms[off[5:0]] != 7'h00) begin
			ch = shift_syms[off[5:0]];
		end
		return ch;
	endfunction

	// Apply one transaction to the tracked state and form its report
	task automatic track_item(input logic [1:0] c, input logic [7:0] sc, input logic dn,
			input logic [10:0] kidx, output key_report_t r);
		logic [2:0]  mbit;
		logic [10:0] idx;
		logic [2:0]  s;
		r = '0;
		case (c)
			CMD_EVENT: begin
				mbit = modifier_of(sc);
				idx  = {3'b000, sc};
				if (mbit != MOD_NONE) begin
					held_mods = dn ? (held_mods | mbit) : (held_mods & ~mbit);
				end else begin
					// a key hit under modifiers marks its bare slot as released unless it is idle
					if (held_mods != MOD_NONE && slot_track[{3'b000, sc}] != SLOT_IDLE) begin
						slot_track[{3'b000, sc}] = SLOT_RELEASED;
					end
					idx = {held_mods, sc};
					r.modifier_flags = {held_mods[0], held_mods[1], held_mods[2]};
				end
				if (dn) begin
					slot_track[idx] = (slot_track[idx] == SLOT_DOWN) ? SLOT_REPEAT : SLOT_DOWN;
					r.ascii_code  = char_for_slot(idx);
					r.ascii_valid = 1'b1;
				end else begin
					slot_track[idx] = slot_track[idx] | SLOT_RELEASED;
				end
				r.slot_index = idx;
				r.slot_state = slot_track[idx];
			end
			CMD_QUERY: begin
				s = slot_track[kidx];
				if (s[2]) begin
					slot_track[kidx] = SLOT_IDLE;
				end else if (s == SLOT_DOWN) begin
					slot_track[kidx] = SLOT_SEEN;
				end
				r.slot_index = kidx;
				r.slot_state = s;
			end
			CMD_CLEAR: begin
				foreach (slot_track[i]) slot_track[i] = SLOT_IDLE;
				held_mods = MOD_NONE;
			end
			default: begin
			end
		endcase
	endtask

	// Compare the result leaving first, then record the transaction entering
	always @(posedge clk or negedge arst_n) begin
		key_report_t got;
		key_report_t want;
		if (!arst_n) begin
			held_mods = MOD_NONE;
			foreach (slot_track[i]) slot_track[i] = SLOT_IDLE;
			report_q.delete();
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = {slot_index, slot_state, modifier_flags, ascii_code, ascii_valid};
				if (report_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("Unexpected result: idx %h state %h mods %h ascii %h/%b",
							got.slot_index, got.slot_state, got.modifier_flags,
							got.ascii_code, got.ascii_valid);
					end
				end else begin
					want = report_q.pop_front();
					checked++;
					if (got.slot_index !== want.slot_index || got.slot_state !== want.slot_state
							|| got.modifier_flags !== want.modifier_flags
							|| got.ascii_code !== want.ascii_code
							|| got.ascii_valid !== want.ascii_valid) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("Mismatch at result %0d: exp idx %h state %h mods %h ascii %h/%b",
								checked, want.slot_index, want.slot_state, want.modifier_flags,
								want.ascii_code, want.ascii_valid);
							$display("                      got idx %h state %h mods %h ascii %h/%b",
								got.slot_index, got.slot_state, got.modifier_flags,
								got.ascii_code, got.ascii_valid);
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				track_item(cmd, scan_code, pressed, key_index, want);
				report_q.push_back(want);
			end
			pending = report_q.size();
		end
	end

endmodule

>>> dv/tb_keyboard_event_tracker.sv
// Testbench top for keyboard_event_tracker: drives key events, queries and clears
// with bursty input and patterned output stalls, and reports the verdict.
// Depends on ket_pkg, keyboard_event_tracker and ket_checker.

module tb_keyboard_event_tracker;
	import ket_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef enum int {STALL_NONE, STALL_COIN, STALL_EVERY_THIRD, STALL_LONG} stall_style_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  cmd;
	logic [7:0]  scan_code;
	logic        pressed;
	logic [10:0] key_index;
	logic        out_valid;
	logic        out_stall;
	logic [10:0] slot_index;
	logic [2:0]  slot_state;
	logic [2:0]  modifier_flags;
	logic [6:0]  ascii_code;
	logic        ascii_valid;

	int fail_count;
	int pending;
	int checked;
	int burst_left;
	int stall_left;
	int n_event;
	int n_query;
	int n_clear;
	int n_unused;
	stall_style_t stall_style;

	logic [7:0] hot_keys [12] = '{8'h1e, 8'h10, 8'h02, 8'h33, 8'h2c, 8'h39,
		8'h1c, 8'h0b, 8'h35, 8'h28, 8'h12, 8'h29};
	logic [7:0] mod_keys [6] = '{SC_ALT_L, SC_ALT_R, SC_CTRL_L, SC_CTRL_R,
		SC_SHIFT_L, SC_SHIFT_R};

	keyboard_event_tracker u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.scan_code      (scan_code),
		.pressed        (pressed),
		.key_index      (key_index),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.slot_index     (slot_index),
		.slot_state     (slot_state),
		.modifier_flags (modifier_flags),
		.ascii_code     (ascii_code),
		.ascii_valid    (ascii_valid)
	);

	ket_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.scan_code      (scan_code),
		.pressed        (pressed),
		.key_index      (key_index),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.slot_index     (slot_index),
		.slot_state     (slot_state),
		.modifier_flags (modifier_flags),
		.ascii_code     (ascii_code),
		.ascii_valid    (ascii_valid),
		.fail_count     (fail_count),
		.pending        (pending),
		.checked        (checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stall results in stretches: free run, coin flips, one stall in three, long holds
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (stall_left == 0) begin
				stall_style = stall_style_t'($urandom_range(0, 3));
				stall_left  = $urandom_range(32, 160);
			end
			stall_left--;
			case (stall_style)
				STALL_NONE:        out_stall <= 1'b0;
				STALL_COIN:        out_stall <= 1'($urandom_range(0, 1));
				STALL_EVERY_THIRD: out_stall <= (stall_left % 3 == 0);
				default:           out_stall <= (stall_left % 16 < 10);
			endcase
		end
	end

	// Present one transaction and hold it until accepted; a random idle gap, possibly none, between bursts
	task automatic send_item(input logic [1:0] c, input logic [7:0] sc, input logic dn,
			input logic [10:0] kidx);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		in_valid  <= 1'b1;
		cmd       <= c;
		scan_code <= sc;
		pressed   <= dn;
		key_index <= kidx;
		do @(posedge clk); while (in_stall);
		burst_left--;
		case (c)
			CMD_EVENT: n_event++;
			CMD_QUERY: n_query++;
			CMD_CLEAR: n_clear++;
			default:   n_unused++;
		endcase
	endtask

	// Drain: drop valid and wait until every expected result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		wait (pending == 0);
	endtask

	initial begin
		int sent;
		int pick;
		logic [7:0]  sc;
		logic [7:0]  mk;
		logic [10:0] kidx;
		logic [1:0]  c;
		logic        dn;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		cmd        <= CMD_EVENT;
		scan_code  <= 8'h00;
		pressed    <= 1'b0;
		key_index  <= 11'h000;
		burst_left = 0;
		n_event    = 0;
		n_query    = 0;
		n_clear    = 0;
		n_unused   = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: press, repeat, release, query advance and the modifier cases
		send_item(CMD_EVENT, 8'h1e, 1'b1, 11'h000);
		send_item(CMD_EVENT, 8'h1e, 1'b1, 11'h000);
		send_item(CMD_EVENT, 8'h1e, 1'b0, 11'h000);
		send_item(CMD_QUERY, 8'h00, 1'b0, 11'h01e);
		send_item(CMD_QUERY, 8'h00, 1'b0, 11'h01e);
		send_item(CMD_EVENT, 8'h10, 1'b1, 11'h000);
		send_item(CMD_QUERY, 8'h00, 1'b0, 11'h010);
		send_item(CMD_QUERY, 8'h00, 1'b0, 11'h010);
		send_item(CMD_EVENT, SC_SHIFT_L, 1'b1, 11'h000);
		send_item(CMD_EVENT, 8'h10, 1'b1, 11'h000);
		send_item(CMD_EVENT, 8'h02, 1'b1, 11'h000);
		send_item(CMD_EVENT, 8'h35, 1'b1, 11'h000);
		send_item(CMD_EVENT, SC_SHIFT_R, 1'b0, 11'h000);
		send_item(CMD_EVENT, SC_ALT_R, 1'b1, 11'h000);
		send_item(CMD_EVENT, SC_CTRL_R, 1'b1, 11'h000);
		send_item(CMD_EVENT, SC_SHIFT_R, 1'b1, 11'h000);
		send_item(CMD_EVENT, 8'hff, 1'b1, 11'h7ff);
		send_item(CMD_EVENT, 8'h00, 1'b0, 11'h000);
		send_item(CMD_EVENT, SC_ALT_L, 1'b0, 11'h000);
		send_item(CMD_EVENT, SC_CTRL_L, 1'b0, 11'h000);
		send_item(CMD_EVENT, SC_SHIFT_L, 1'b0, 11'h000);
		send_item(CMD_EVENT, 8'hd3, 1'b1, 11'h000);
		send_item(CMD_QUERY, 8'h00, 1'b0, 11'h7ff);
		send_item(CMD_QUERY, 8'hff, 1'b1, 11'h000);
		send_item(CMD_UNUSED, 8'hff, 1'b1, 11'h7ff);
		send_item(CMD_CLEAR, 8'h00, 1'b0, 11'h000);
		send_item(CMD_QUERY, 8'h00, 1'b0, 11'h410);
		drain_results();

		// Random: modifier chords around hot keys, mixed with single items and noise
		sent = 0;
		while (sent < 950) begin
			if (sent >= 400 && sent < 410) begin
				drain_results();
				sent = 410;
			end
			pick = $urandom_range(0, 199);
			if (pick < 50) begin
				mk = mod_keys[$urandom_range(0, 5)];
				sc = hot_keys[$urandom_range(0, 11)];
				send_item(CMD_EVENT, mk, 1'b1, 11'($urandom));
				send_item(CMD_EVENT, sc, 1'b1, 11'($urandom));
				if ($urandom_range(0, 1) == 1) begin
					send_item(CMD_EVENT, sc, 1'b1, 11'($urandom));
				end
				send_item(CMD_EVENT, sc, 1'b0, 11'($urandom));
				if ($urandom_range(0, 9) < 7) begin
					send_item(CMD_EVENT, mk, 1'b0, 11'($urandom));
				end
				sent += 4;
			end else begin
				c    = CMD_EVENT;
				sc   = 8'($urandom);
				dn   = ($urandom_range(0, 9) < 6);
				kidx = 11'($urandom);
				if (pick < 110) begin
					sc = hot_keys[$urandom_range(0, 11)];
				end else if (pick < 135) begin
					sc = mod_keys[$urandom_range(0, 5)];
				end else if (pick < 150) begin
					dn = 1'($urandom_range(0, 1));
				end else if (pick < 192) begin
					c = CMD_QUERY;
					if ($urandom_range(0, 9) >= 3) begin
						kidx = {3'($urandom), hot_keys[$urandom_range(0, 11)]};
					end
				end else if (pick < 196) begin
					c = CMD_UNUSED;
				end else begin
					c = CMD_CLEAR;
				end
				send_item(c, sc, dn, kidx);
				sent++;
			end
		end

		// Wind down and let any stray result show up
		drain_results();
		repeat (16) @(posedge clk);
		$display("Ran %0d key events, %0d slot queries, %0d clears, %0d unused commands.",
			n_event, n_query, n_clear, n_unused);
		$display("Compared %0d results, %0d mismatches, %0d left outstanding.",
			checked, fail_count, pending);
		if (fail_count == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run, clearing passes included
	initial begin
		#5000000;
		$display("Timed out with %0d results outstanding", pending);
		$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/ket_pkg.sv
hw/rtl/ket_dpath.sv
hw/rtl/ket_ctrl.sv
hw/rtl/keyboard_event_tracker.sv
dv/ket_checker.sv
dv/tb_keyboard_event_tracker.sv
